// ===== rtl/core/erode_pkg.sv =====
// Package for the 19x19 grayscale erosion pipeline.
// Holds pixel and stage types, sizes and the pairwise-minimum helpers.
// No dependencies.
package erode_pkg;

  localparam int WINDOW_SIZE = 19;
  localparam int PIXEL_BITS  = 8;
  // The column and the window are both folded into a 16-entry stage first.
  localparam int LOAD_DEPTH    = 16;
  localparam int DIRECT_PIXELS = 2 * LOAD_DEPTH - WINDOW_SIZE;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  localparam pixel_t PIX_MAX = {PIXEL_BITS{1'b1}};

  typedef pixel_t [WINDOW_SIZE-1:0]    window_t;
  typedef pixel_t [LOAD_DEPTH-1:0]     stage_a_t;
  typedef pixel_t [LOAD_DEPTH/2-1:0]   stage_b_t;
  typedef pixel_t [LOAD_DEPTH/4-1:0]   stage_c_t;
  typedef pixel_t [LOAD_DEPTH/8-1:0]   stage_d_t;

  function automatic pixel_t min_pix(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  // The leading entries pass straight through; the trailing ones go in pairwise.
  function automatic stage_a_t load_stage(input window_t src);
    stage_a_t dst;
    for (int i = 0; i < DIRECT_PIXELS; i++) begin
      dst[i] = src[i];
    end
    for (int i = DIRECT_PIXELS; i < LOAD_DEPTH; i++) begin
      dst[i] = min_pix(src[2*i - DIRECT_PIXELS], src[2*i - DIRECT_PIXELS + 1]);
    end
    return dst;
  endfunction

endpackage

// ===== rtl/core/grayscale_erosion_19x19.sv =====
// Top level of the streaming 19x19 flat grayscale erosion pipeline.
// Depends on erode_pkg for pixel types, stage sizes and minimum helpers.
//
// Usage:
//   The input channel (in_valid / in_stall) takes one item per cycle while
//   in_stall is low: an init flag and one 19-pixel column split over
//   column_low, column_mid and column_high. The output channel (out_valid /
//   out_stall) returns exactly one eroded_pixel for every accepted item, in order.
//   The result of an item is the minimum of the last reduction pair as it
//   stood before that item advanced the pipeline, so it shows up on the
//   output register in the cycle after acceptance. Throughput is one item
//   per cycle while the output is not stalled; every stage is a register
//   and the logic between registers is at most one 8-bit compare and select.
//   The pipeline only advances on an accepted item, so the image data needs
//   many items to travel from the column input to the output; until then the
//   output carries the 255 fill value.
//   An item with init set returns 255, refills every stage past the column
//   load stage with 255 and loads its column as usual.
//   Reset fills every stage with 255 and empties the output register.
//   When the receiver stalls, the result is held and in_stall rises only
//   while the output register is full and stalled.
module grayscale_erosion_19x19 (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    init,
  input  logic [63:0]             column_low,
  input  logic [63:0]             column_mid,
  input  logic [23:0]             column_high,
  output logic                    out_valid,
  input  logic                    out_stall,
  output erode_pkg::pixel_t       eroded_pixel
);
  import erode_pkg::*;

  stage_a_t column_stage_a;
  stage_b_t column_stage_b;
  stage_c_t column_stage_c;
  stage_d_t column_stage_d;
  window_t  column_min_window;
  stage_a_t row_stage_a;
  stage_b_t row_stage_b;
  stage_c_t row_stage_c;
  stage_d_t row_stage_d;

  window_t  pix;
  pixel_t   result;
  logic     accept;

  assign pix      = window_t'({column_high, column_mid, column_low});
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign result   = init ? PIX_MAX : min_pix(row_stage_d[0], row_stage_d[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_stage_a    <= '1;
      column_stage_b    <= '1;
      column_stage_c    <= '1;
      column_stage_d    <= '1;
      column_min_window <= '1;
      row_stage_a       <= '1;
      row_stage_b       <= '1;
      row_stage_c       <= '1;
      row_stage_d       <= '1;
    end else if (accept) begin
      column_stage_a <= load_stage(pix);
      if (init) begin
        column_stage_b    <= '1;
        column_stage_c    <= '1;
        column_stage_d    <= '1;
        column_min_window <= '1;
        row_stage_a       <= '1;
        row_stage_b       <= '1;
        row_stage_c       <= '1;
        row_stage_d       <= '1;
      end else begin
        for (int i = 0; i < LOAD_DEPTH/2; i++) begin
          column_stage_b[i] <= min_pix(column_stage_a[2*i], column_stage_a[2*i+1]);
          row_stage_b[i]    <= min_pix(row_stage_a[2*i], row_stage_a[2*i+1]);
        end
        for (int i = 0; i < LOAD_DEPTH/4; i++) begin
          column_stage_c[i] <= min_pix(column_stage_b[2*i], column_stage_b[2*i+1]);
          row_stage_c[i]    <= min_pix(row_stage_b[2*i], row_stage_b[2*i+1]);
        end
        for (int i = 0; i < LOAD_DEPTH/8; i++) begin
          column_stage_d[i] <= min_pix(column_stage_c[2*i], column_stage_c[2*i+1]);
          row_stage_d[i]    <= min_pix(row_stage_c[2*i], row_stage_c[2*i+1]);
        end
        // The window shifts by one column; the newest column minimum enters at 0.
        for (int i = 1; i < WINDOW_SIZE; i++) begin
          column_min_window[i] <= column_min_window[i-1];
        end
        column_min_window[0] <= min_pix(column_stage_d[0], column_stage_d[1]);
        row_stage_a          <= load_stage(column_min_window);
      end
    end
  end

  // Output register: refilled on every accepted item, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eroded_pixel <= result;
    end
  end

  a_init_output: assert property (@(posedge clk) disable iff (rst)
    accept && init |=> out_valid && eroded_pixel == PIX_MAX)
    else $error("init item did not return the fill value");

  a_init_fill: assert property (@(posedge clk) disable iff (rst)
    accept && init |=> row_stage_d[0] == PIX_MAX && row_stage_d[1] == PIX_MAX &&
                       column_min_window[WINDOW_SIZE-1] == PIX_MAX)
    else $error("init item did not refill the pipeline");

  a_window_entry: assert property (@(posedge clk) disable iff (rst)
    accept && !init |=> column_min_window[0] ==
                        min_pix($past(column_stage_d[0]), $past(column_stage_d[1])))
    else $error("column minimum did not enter the window");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(row_stage_d) && $stable(column_min_window) &&
                $stable(column_stage_a))
    else $error("pipeline advanced without an accepted item");

endmodule
